// File: hdl/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg
// shared types, character codes and the digit decode for the integer parser
// ----------------------------------------------------------------------------
`default_nettype none

package stip_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [5:0] NOT_DIGIT  = 6'h3F;
	localparam logic [5:0] RADIX_AUTO = 6'd0;
	localparam logic [5:0] BASE_OCT   = 6'd8;
	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_HEX   = 6'd16;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_DONE,
		PH_SPACE,
		PH_PREFIX,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       begin_req;
	} in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [15:0]        consumed;
		logic               overflow;
	} out_t;

	// classified character as held in the queue
	typedef struct packed {
		logic       begin_req;
		logic [5:0] digit;
		logic       is_space;
		logic       is_sign;
		logic       is_minus;
		logic       is_x;
	} cls_t;

	function automatic logic [5:0] digit_of(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= CH_0 && c <= CH_9) begin
			t = c - CH_0;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			t = c - CH_UA + 8'd10;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			t = c - CH_LA + 8'd10;
		end else begin
			t = {2'b00, NOT_DIGIT};
		end
		return t[5:0];
	endfunction

endpackage

`default_nettype wire

// File: hdl/stip_front.sv
// ----------------------------------------------------------------------------
// stip_front
// input side: takes characters and classifies them into queue entries
// ----------------------------------------------------------------------------
`default_nettype none

module stip_front (
	input  wire logic           in_valid,
	input  wire stip_pkg::in_t  in_data,
	output logic                in_stall,
	input  wire logic           full,
	output logic                push,
	output stip_pkg::cls_t      push_data
);

	assign in_stall = full;
	assign push     = in_valid && !full;

	always_comb begin
		push_data.begin_req = in_data.begin_req;
		push_data.digit     = stip_pkg::digit_of(in_data.ch);
		push_data.is_space  = (in_data.ch == stip_pkg::CH_SPACE) ||
			(in_data.ch >= stip_pkg::CH_TAB && in_data.ch <= stip_pkg::CH_CR);
		push_data.is_sign   = (in_data.ch == stip_pkg::CH_PLUS) ||
			(in_data.ch == stip_pkg::CH_MINUS);
		push_data.is_minus  = (in_data.ch == stip_pkg::CH_MINUS);
		push_data.is_x      = (in_data.ch == stip_pkg::CH_LX) ||
			(in_data.ch == stip_pkg::CH_UX);
	end

endmodule

`default_nettype wire

// File: hdl/stip_queue.sv
// ----------------------------------------------------------------------------
// stip_queue
// short queue of classified characters between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module stip_queue #(
	parameter int DEPTH = stip_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire stip_pkg::cls_t push_data,
	output logic                full,
	output logic                head_valid,
	output stip_pkg::cls_t      head_data,
	input  wire logic           pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	stip_pkg::cls_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/stip_back.sv
// ----------------------------------------------------------------------------
// stip_back
// parse sequencer: prefix and sign handling, multiply-add and result register
// ----------------------------------------------------------------------------
`default_nettype none

module stip_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [5:0]     cfg_data,
	input  wire logic           head_valid,
	input  wire stip_pkg::cls_t head_data,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output stip_pkg::out_t      out_data
);

	logic [5:0]       radix_q;
	stip_pkg::phase_t phase_q, phase_d, ph_eff;
	logic             neg_q, neg_d, neg_eff;
	logic [31:0]      acc_q, acc_d, acc_eff;
	logic [5:0]       base_q, base_d, base_eff;
	logic [15:0]      cnt_q, cnt_d, cnt_eff;
	logic             ovf_q, ovf_d, ovf_eff;
	logic             out_valid_q;
	stip_pkg::out_t   out_q;

	logic        out_free;
	logic        sel_prefix, pref_zero, sel_digit, digit_ok, finish, accum, take;
	logic [5:0]  base_pref, mul_base;
	logic [38:0] prod;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = head_valid && out_free;

	// begin restarts the parse with cleared state
	assign ph_eff   = head_data.begin_req ? stip_pkg::PH_SPACE : phase_q;
	assign neg_eff  = head_data.begin_req ? 1'b0 : neg_q;
	assign acc_eff  = head_data.begin_req ? 32'd0 : acc_q;
	assign base_eff = head_data.begin_req ? 6'd0 : base_q;
	assign cnt_eff  = head_data.begin_req ? 16'd0 : cnt_q;
	assign ovf_eff  = head_data.begin_req ? 1'b0 : ovf_q;

	assign base_pref  = (radix_q == stip_pkg::RADIX_AUTO) ? stip_pkg::BASE_DEC : radix_q;
	assign sel_prefix = (ph_eff == stip_pkg::PH_PREFIX) ||
		(ph_eff == stip_pkg::PH_SPACE && !head_data.is_space && !head_data.is_sign);
	assign pref_zero  = sel_prefix && (head_data.digit == 6'd0) &&
		(radix_q == stip_pkg::RADIX_AUTO || radix_q == stip_pkg::BASE_HEX);
	assign sel_digit  = (sel_prefix && !pref_zero) || (ph_eff == stip_pkg::PH_DIGITS) ||
		(ph_eff == stip_pkg::PH_ZERO && !head_data.is_x);
	assign mul_base   = sel_prefix ? base_pref : base_eff;
	assign digit_ok   = head_data.digit < mul_base;
	assign finish     = sel_digit && !digit_ok;
	assign accum      = sel_digit && digit_ok;
	assign take       = (ph_eff != stip_pkg::PH_DONE) && !finish;
	assign prod       = {7'd0, acc_eff} * {33'd0, mul_base} + {33'd0, head_data.digit};

	// next state
	always_comb begin
		phase_d = phase_q;
		if (pop) begin
			unique case (ph_eff)
				stip_pkg::PH_DONE: begin
					phase_d = stip_pkg::PH_DONE;
				end
				stip_pkg::PH_SPACE, stip_pkg::PH_PREFIX: begin
					if (ph_eff == stip_pkg::PH_SPACE && head_data.is_space) begin
						phase_d = stip_pkg::PH_SPACE;
					end else if (ph_eff == stip_pkg::PH_SPACE && head_data.is_sign) begin
						phase_d = stip_pkg::PH_PREFIX;
					end else if (pref_zero) begin
						phase_d = stip_pkg::PH_ZERO;
					end else begin
						phase_d = finish ? stip_pkg::PH_DONE : stip_pkg::PH_DIGITS;
					end
				end
				stip_pkg::PH_ZERO, stip_pkg::PH_DIGITS: begin
					phase_d = finish ? stip_pkg::PH_DONE : stip_pkg::PH_DIGITS;
				end
				default: begin
					phase_d = stip_pkg::PH_DONE;
				end
			endcase
		end
	end

	// datapath
	always_comb begin
		neg_d = neg_eff;
		if (ph_eff == stip_pkg::PH_SPACE && !head_data.is_space && head_data.is_sign) begin
			neg_d = head_data.is_minus;
		end
		priority if (pref_zero) begin
			base_d = (radix_q == stip_pkg::RADIX_AUTO) ? stip_pkg::BASE_OCT : stip_pkg::BASE_HEX;
		end else if (ph_eff == stip_pkg::PH_ZERO && head_data.is_x) begin
			base_d = stip_pkg::BASE_HEX;
		end else begin
			base_d = mul_base;
		end
		acc_d = accum ? prod[31:0] : (pref_zero ? 32'd0 : acc_eff);
		ovf_d = ovf_eff || (accum && (prod[38:31] != 8'd0));
		cnt_d = (take && cnt_eff != stip_pkg::COUNT_MAX) ? cnt_eff + 16'd1 : cnt_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= stip_pkg::RADIX_AUTO;
		end else if (cfg_valid) begin
			radix_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stip_pkg::PH_DONE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			base_q  <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (pop) begin
				neg_q  <= neg_d;
				acc_q  <= acc_d;
				base_q <= base_d;
				cnt_q  <= cnt_d;
				ovf_q  <= ovf_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && finish) begin
			out_q.value    <= neg_eff ? $signed(32'd0 - acc_eff) : $signed(acc_eff);
			out_q.consumed <= cnt_eff;
			out_q.overflow <= ovf_eff;
		end
	end

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !pop)
		else $error("result register overwritten while held");

	a_finish_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop && finish |=> phase_q == stip_pkg::PH_DONE && out_valid_q)
		else $error("terminating transfer did not end the parse");

	a_zero_base: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == stip_pkg::PH_ZERO |->
			base_q == stip_pkg::BASE_OCT || base_q == stip_pkg::BASE_HEX)
		else $error("leading zero phase with wrong base");

	a_digits_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == stip_pkg::PH_DIGITS |-> cnt_q != 16'd0)
		else $error("digit phase with nothing consumed");
`endif

endmodule

`default_nettype wire

// File: hdl/string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// string_to_integer_parser
// streaming strtol-style parser, one character per transfer
// ----------------------------------------------------------------------------
// Takes one character per cycle while in_stall is low. A character with
// begin_req set starts a new string; leading whitespace, one sign and, for
// radix 0 or 16, a 0x prefix are taken, then digits below the base are
// accumulated with one 32 by 6 bit multiply-add per digit. The first
// character that cannot continue the number produces one result (value,
// consumed, overflow); later characters without begin_req are dropped. The
// front classifies each character into a queue of QUEUE_DEPTH entries; the
// back pops one entry per cycle while its result register is free, and a
// result is registered from the popped terminating character. The radix
// register must only be written while the parser is idle.
`default_nettype none

module string_to_integer_parser #(
	parameter int QUEUE_DEPTH = stip_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [5:0]     cfg_data,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire stip_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output stip_pkg::out_t      out_data
);

	logic           full, push, head_valid, pop;
	stip_pkg::cls_t push_data, head_data;

	stip_front u_front (
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	stip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	stip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data)
	);

endmodule

`default_nettype wire

// File: sim/tb_string_to_integer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_to_integer_parser
// self-checking bench for the streaming integer parser
// ----------------------------------------------------------------------------
// Feeds strings one character per transfer under a range of radix settings:
// a few hand-picked strings, then mostly well-formed random numbers with
// random prefixes, signs, digits and terminators, mixed with noise. A
// scoreboard predicts each result from the accepted characters and checks
// every result transfer in order. Both sides idle at random; the receiver
// holds off once for a long stretch so that the parser fills and stalls.
// ----------------------------------------------------------------------------

class parse_scoreboard;
	logic [5:0]        radix;
	stip_pkg::phase_t  ph;
	bit                neg;
	logic [31:0]       acc;
	logic [5:0]        base;
	logic [15:0]       taken;
	bit                ovf;
	stip_pkg::out_t    awaited[$];
	int                mismatches;

	function new();
		radix = stip_pkg::RADIX_AUTO;
		ph = stip_pkg::PH_DONE;
		neg = 1'b0;
		acc = '0;
		base = '0;
		taken = '0;
		ovf = 1'b0;
		mismatches = 0;
	endfunction

	function void set_radix(logic [5:0] r);
		radix = r;
	endfunction

	function void take();
		if (taken != stip_pkg::COUNT_MAX) begin
			taken++;
		end
	endfunction

	function int char_value(logic [7:0] c);
		if (c >= stip_pkg::CH_0 && c <= stip_pkg::CH_9) begin
			return c - stip_pkg::CH_0;
		end
		if (c >= stip_pkg::CH_UA && c <= stip_pkg::CH_UZ) begin
			return c - stip_pkg::CH_UA + 10;
		end
		if (c >= stip_pkg::CH_LA && c <= stip_pkg::CH_LZ) begin
			return c - stip_pkg::CH_LA + 10;
		end
		return -1;
	endfunction

	function void emit();
		stip_pkg::out_t r;
		r.value = neg ? -acc : acc;
		r.consumed = taken;
		r.overflow = ovf;
		awaited.push_back(r);
		ph = stip_pkg::PH_DONE;
	endfunction

	function void digit_step(logic [7:0] c);
		int d;
		logic [63:0] next;
		d = char_value(c);
		if (d < 0) begin
			emit();
			return;
		end
		if (d >= int'(base)) begin
			emit();
			return;
		end
		next = 64'(acc) * 64'(base) + 64'(d);
		if (next > 64'h7FFF_FFFF) begin
			ovf = 1'b1;
		end
		acc = next[31:0];
		take();
		ph = stip_pkg::PH_DIGITS;
	endfunction

	function void prefix_step(logic [7:0] c);
		if ((radix == stip_pkg::RADIX_AUTO || radix == stip_pkg::BASE_HEX) &&
				c == stip_pkg::CH_0) begin
			base = (radix == stip_pkg::RADIX_AUTO) ? stip_pkg::BASE_OCT : stip_pkg::BASE_HEX;
			acc = '0;
			take();
			ph = stip_pkg::PH_ZERO;
		end else begin
			base = (radix == stip_pkg::RADIX_AUTO) ? stip_pkg::BASE_DEC : radix;
			digit_step(c);
		end
	endfunction

	function void note_char(stip_pkg::in_t item);
		logic [7:0] c;
		c = item.ch;
		if (item.begin_req) begin
			ph = stip_pkg::PH_SPACE;
			neg = 1'b0;
			acc = '0;
			base = '0;
			taken = '0;
			ovf = 1'b0;
		end
		case (ph)
			stip_pkg::PH_SPACE: begin
				if (c == stip_pkg::CH_SPACE ||
						(c >= stip_pkg::CH_TAB && c <= stip_pkg::CH_CR)) begin
					take();
				end else if (c == stip_pkg::CH_PLUS || c == stip_pkg::CH_MINUS) begin
					neg = (c == stip_pkg::CH_MINUS);
					take();
					ph = stip_pkg::PH_PREFIX;
				end else begin
					prefix_step(c);
				end
			end
			stip_pkg::PH_PREFIX: begin
				prefix_step(c);
			end
			stip_pkg::PH_ZERO: begin
				if (c == stip_pkg::CH_LX || c == stip_pkg::CH_UX) begin
					base = stip_pkg::BASE_HEX;
					take();
					ph = stip_pkg::PH_DIGITS;
				end else begin
					digit_step(c);
				end
			end
			stip_pkg::PH_DIGITS: begin
				digit_step(c);
			end
			default: begin
			end
		endcase
	endfunction

	task flag_mismatch(string msg);
		if (mismatches < 200) begin
			$display("mismatch: %s", msg);
		end
		mismatches++;
	endtask

	task check_result(stip_pkg::out_t got);
		stip_pkg::out_t want;
		if (awaited.size() == 0) begin
			flag_mismatch($sformatf("result with none awaited: value %0d consumed %0d",
				got.value, got.consumed));
			return;
		end
		want = awaited.pop_front();
		if (got.value !== want.value) begin
			flag_mismatch($sformatf("value %0d, predicted %0d", got.value, want.value));
		end
		if (got.consumed !== want.consumed) begin
			flag_mismatch($sformatf("consumed %0d, predicted %0d",
				got.consumed, want.consumed));
		end
		if (got.overflow !== want.overflow) begin
			flag_mismatch($sformatf("overflow %0b, predicted %0b",
				got.overflow, want.overflow));
		end
	endtask
endclass

module tb_string_to_integer_parser;

	typedef logic [7:0] text_t[$];

	localparam int         CYCLE_LIMIT   = 1000000;
	localparam int         SETTLE_CYCLES = 10;
	localparam int         HOLD_CYCLES   = 400;
	localparam logic [7:0] TERMINATOR    = 8'h00;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [5:0]     cfg_data = '0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	stip_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	stip_pkg::out_t out_data;

	logic [5:0] cur_radix = stip_pkg::RADIX_AUTO;
	bit         send_idle = 1'b0;
	bit         recv_idle = 1'b0;
	bit         pressure = 1'b0;

	parse_scoreboard sb = new();

	string_to_integer_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #10 clk = ~clk;

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// result side: checks every transfer and drives the stall pattern
	initial begin : receiver
		int run_left;
		int hold_left;
		bit run_stall;
		bit held_off;
		run_left = 0;
		hold_left = 0;
		run_stall = 1'b0;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && !out_stall) begin
					sb.check_result(out_data);
				end
				if (pressure && !held_off) begin
					held_off = 1'b1;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left > 0) begin
					hold_left--;
					out_stall <= 1'b1;
				end else begin
					if (run_left == 0) begin
						run_stall = recv_idle && ($urandom_range(0, 1) == 1);
						run_left = run_stall ? gap_len() + 1 : $urandom_range(1, 10);
					end
					run_left--;
					out_stall <= run_stall;
				end
			end
		end
	end

	task automatic send_char(stip_pkg::in_t item);
		int gap;
		gap = send_idle ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		sb.note_char(item);
	endtask

	task automatic send_text(text_t t);
		stip_pkg::in_t item;
		foreach (t[i]) begin
			item.ch = t[i];
			item.begin_req = (i == 0);
			send_char(item);
		end
	endtask

	task automatic send_spelled(string s, logic [7:0] last);
		text_t t;
		for (int i = 0; i < s.len(); i++) begin
			t.push_back(s[i]);
		end
		t.push_back(last);
		send_text(t);
	endtask

	// wait for every predicted result, then let the back end go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(logic [5:0] r);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_radix(r);
		cur_radix = r;
	endtask

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) begin
			return stip_pkg::CH_0 + 8'(d);
		end
		return ($urandom_range(0, 1) == 1) ? stip_pkg::CH_UA + 8'(d - 10) :
			stip_pkg::CH_LA + 8'(d - 10);
	endfunction

	function automatic void build_number(ref text_t t);
		int eff;
		int ndig;
		int r;
		int d;
		t.delete();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				r = $urandom_range(0, 6);
				t.push_back((r > 4) ? stip_pkg::CH_SPACE : stip_pkg::CH_TAB + 8'(r));
			end
		end
		case ($urandom_range(0, 3))
			1: t.push_back(stip_pkg::CH_PLUS);
			2: t.push_back(stip_pkg::CH_MINUS);
			default: begin
			end
		endcase
		if (cur_radix == stip_pkg::RADIX_AUTO) begin
			eff = 10;
		end else if (cur_radix > 36) begin
			eff = 36;
		end else begin
			eff = cur_radix;
		end
		if ((cur_radix == stip_pkg::RADIX_AUTO || cur_radix == stip_pkg::BASE_HEX) &&
				$urandom_range(0, 2) == 0) begin
			t.push_back(stip_pkg::CH_0);
			if ($urandom_range(0, 1) == 1) begin
				t.push_back(($urandom_range(0, 1) == 1) ? stip_pkg::CH_LX : stip_pkg::CH_UX);
				eff = 16;
			end else if (cur_radix == stip_pkg::RADIX_AUTO) begin
				eff = 8;
			end
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			ndig = 0;
		end else if (r < 85) begin
			ndig = $urandom_range(1, 6);
		end else begin
			ndig = $urandom_range(7, 14);
		end
		repeat (ndig) begin
			if ($urandom_range(0, 19) == 0) begin
				d = $urandom_range(0, 35);
			end else begin
				d = $urandom_range(0, eff - 1);
			end
			t.push_back(digit_char(d));
		end
		t.push_back(($urandom_range(0, 1) == 1) ? TERMINATOR : 8'($urandom_range(0, 255)));
	endfunction

	task automatic run_phase(logic [5:0] r, int budget, bit s_idle, bit r_idle, bit squeeze);
		text_t t;
		stip_pkg::in_t item;
		int sent;
		write_radix(r);
		send_idle = s_idle;
		recv_idle <= r_idle;
		pressure <= squeeze;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 9) < 8) begin
				build_number(t);
				send_text(t);
				sent += t.size();
				if ($urandom_range(0, 7) == 0) begin
					item.ch = 8'($urandom_range(0, 255));
					item.begin_req = 1'b0;
					send_char(item);
				end
			end else begin
				// noise with scattered restarts
				repeat ($urandom_range(1, 6)) begin
					item.ch = 8'($urandom_range(0, 255));
					item.begin_req = ($urandom_range(0, 2) == 0);
					send_char(item);
					sent++;
				end
			end
		end
		pressure <= 1'b0;
	endtask

	initial begin : stimulus
		stip_pkg::in_t item;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		write_radix(stip_pkg::RADIX_AUTO);
		send_idle = 1'b1;
		recv_idle <= 1'b1;
		item.ch = 8'hFF;
		item.begin_req = 1'b0;
		send_char(item);
		send_spelled(" \t-0x", 8'h67);
		send_spelled("0X", stip_pkg::CH_LX);
		send_spelled("-2147483648", 8'hFF);
		send_spelled("", TERMINATOR);

		run_phase(stip_pkg::RADIX_AUTO, 140, 1'b1, 1'b1, 1'b0);
		run_phase(stip_pkg::BASE_DEC, 140, 1'b1, 1'b0, 1'b0);
		run_phase(stip_pkg::BASE_HEX, 140, 1'b0, 1'b1, 1'b0);
		run_phase(6'd2, 140, 1'b1, 1'b1, 1'b0);
		run_phase(stip_pkg::BASE_OCT, 140, 1'b0, 1'b0, 1'b0);
		run_phase(6'd36, 140, 1'b1, 1'b1, 1'b0);
		run_phase(stip_pkg::BASE_DEC, 160, 1'b0, 1'b0, 1'b1);
		run_phase(6'd1, 100, 1'b1, 1'b1, 1'b0);
		run_phase(6'd37, 100, 1'b1, 1'b1, 1'b0);
		run_phase(6'd63, 120, 1'b0, 1'b1, 1'b0);
		run_phase(6'($urandom_range(3, 35)), 120, 1'b1, 1'b1, 1'b0);
		run_phase(stip_pkg::RADIX_AUTO, 140, 1'b1, 1'b1, 1'b0);

		settle();
		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/stip_pkg.sv
hdl/stip_front.sv
hdl/stip_queue.sv
hdl/stip_back.sv
hdl/string_to_integer_parser.sv
sim/tb_string_to_integer_parser.sv
